FILE: design/mts_pkg.sv
// Shared types, constants and the tag pattern table for the markup tag stripper.
`default_nettype none

package mts_pkg;

   localparam int NUM_PATTERNS = 9;
   localparam int PAT_SLOTS    = 8;

   typedef logic [7:0] char_type;
   typedef logic [2:0] pos_type;
   typedef logic [NUM_PATTERNS-1:0] cand_type;

   localparam char_type CHAR_LT    = 8'h3C;
   localparam char_type CHAR_GT    = 8'h3E;
   localparam char_type CHAR_NL    = 8'h0A;
   localparam char_type CHAR_DASH  = 8'h2D;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_NONE  = 8'h00;

   // Pattern slots with a special action
   localparam int PAT_LV6 = 7;
   localparam int PAT_EXA = 8;

   localparam char_type PATTERN_TEXT [NUM_PATTERNS][PAT_SLOTS] = '{
      '{"<", "/", "L", "V", "0", ">", CHAR_NONE, CHAR_NONE},
      '{"<", "/", "L", "V", "2", ">", CHAR_NONE, CHAR_NONE},
      '{"<", "/", "L", "V", "3", ">", CHAR_NONE, CHAR_NONE},
      '{"<", "/", "L", "V", "4", ">", CHAR_NONE, CHAR_NONE},
      '{"<", "/", "L", "V", "5", ">", CHAR_NONE, CHAR_NONE},
      '{"<", "L", "V", "2", ">", CHAR_NONE, CHAR_NONE, CHAR_NONE},
      '{"<", "L", "V", "3", ">", CHAR_NONE, CHAR_NONE, CHAR_NONE},
      '{"<", "L", "V", "6", CHAR_NONE, CHAR_NONE, CHAR_NONE, CHAR_NONE},
      '{"<", "E", "X", "A", ">", CHAR_NONE, CHAR_NONE, CHAR_NONE}
   };

   localparam pos_type PATTERN_LEN [NUM_PATTERNS] = '{
      3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd5
   };

   typedef struct packed {
      logic [1:0] out_count;
      char_type   out_first;
      char_type   out_second;
      logic       text_end;
   } result_type;

endpackage

`default_nettype wire

FILE: design/mts_scan.sv
// Tag scanner: holds the scan state and works out one result per request.
`default_nettype none

module mts_scan
   import mts_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     accept,
   input  wire char_type text_byte,
   input  wire logic     last,
   output result_type    result
);

   typedef enum logic [1:0] {
      MODE_TEXT    = 2'd0,
      MODE_MATCH   = 2'd1,
      MODE_SKIPTAG = 2'd2,
      MODE_DROP1   = 2'd3
   } mode_type;

   mode_type mode_ff, mode_in;
   pos_type  pos_ff, pos_in;
   cand_type cand_ff, cand_in;
   cand_type hit;
   cand_type fin;

   always_comb begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
         hit[i] = cand_ff[i] && (pos_ff < PATTERN_LEN[i])
                  && (PATTERN_TEXT[i][pos_ff] == text_byte);
         fin[i] = hit[i] && (({1'b0, pos_ff} + 4'd1) == {1'b0, PATTERN_LEN[i]});
      end
   end

   always_comb begin
      mode_in           = mode_ff;
      pos_in            = pos_ff;
      cand_in           = cand_ff;
      result.out_count  = 2'd0;
      result.out_first  = CHAR_NONE;
      result.out_second = CHAR_NONE;
      result.text_end   = last;
      unique case (mode_ff)
         MODE_TEXT: begin
            if (text_byte == CHAR_LT) begin
               mode_in = MODE_MATCH;
               pos_in  = 3'd1;
               cand_in = '1;
            end else begin
               result.out_count = 2'd1;
               result.out_first = text_byte;
            end
         end
         MODE_MATCH: begin
            priority if (|fin) begin
               if (fin[PAT_EXA]) begin
                  result.out_count  = 2'd2;
                  result.out_first  = CHAR_DASH;
                  result.out_second = CHAR_SPACE;
               end else begin
                  result.out_count = 2'd1;
                  result.out_first = CHAR_NL;
               end
               mode_in = fin[PAT_LV6] ? MODE_DROP1 : MODE_TEXT;
               pos_in  = '0;
               cand_in = '0;
            end else if (hit == '0) begin
               mode_in = (text_byte == CHAR_GT) ? MODE_TEXT : MODE_SKIPTAG;
               pos_in  = '0;
               cand_in = '0;
            end else begin
               pos_in  = pos_ff + 3'd1;
               cand_in = hit;
            end
         end
         MODE_SKIPTAG: begin
            if (text_byte == CHAR_GT) begin
               mode_in = MODE_TEXT;
            end
         end
         MODE_DROP1: begin
            mode_in = MODE_TEXT;
         end
         default: begin
            mode_in = MODE_TEXT;
         end
      endcase
      // end of text: start afresh
      if (last) begin
         mode_in = MODE_TEXT;
         pos_in  = '0;
         cand_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         pos_ff  <= '0;
         cand_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         cand_ff <= cand_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/mts_out_buffer.sv
// Result register with a skid stage that catches one further request under a stall.
`default_nettype none

module mts_out_buffer
   import mts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            can_push,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_data_ff, main_data_in;
   result_type skid_data_ff, skid_data_in;

   assign can_push  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (main_valid_ff && out_ready) begin
         // advance skid into the main register, or refill from a push
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_data_in = push_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end else begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

FILE: design/markup_tag_stripper.sv
// Top level of the markup tag stripper: scanner plus result buffer.
//
// Usage: feed definition text one byte per request on the req_ channel, with
// req_last high on the final byte. Every request gives exactly one result on
// the rsp_ channel: rsp_out_count (0 to 2) bytes in rsp_out_first and
// rsp_out_second, and rsp_text_end copying req_last. Plain text passes
// through; tags are dropped, except the recognised level and example tags,
// which give a newline or a dash and a space on their closing byte.
// Output: each result is registered, in the result register or the skid stage.
// Throughput: one request per cycle while rsp_ready is high; the pattern
// compare against the tag table is combinational and feeds the result register.
// Stall: while rsp_ready is low the result holds; one further request is
// caught in a skid stage, after which req_ready drops until the receiver
// drains a result.
// Reset: synchronous, active high; clears the scan state and empties both
// result stages. The final byte of a text also returns the scan state to
// its reset value, dropping any unterminated tag.
`default_nettype none

module markup_tag_stripper
   import mts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_text_byte,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_out_count,
   output logic [7:0]      rsp_out_first,
   output logic [7:0]      rsp_out_second,
   output logic            rsp_text_end
);

   logic       accept;
   result_type scan_result;
   result_type rsp_data;

   // take a request whenever the skid stage is free
   assign accept = req_valid && req_ready;

   mts_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .last      (req_last),
      .result    (scan_result)
   );

   mts_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (scan_result),
      .can_push  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // unpack the held result onto the ports
   assign rsp_out_count  = rsp_data.out_count;
   assign rsp_out_first  = rsp_data.out_first;
   assign rsp_out_second = rsp_data.out_second;
   assign rsp_text_end   = rsp_data.text_end;

endmodule

`default_nettype wire

FILE: design/mts_checker.sv
// Port-level checks for the markup tag stripper, bound to the top level.
`default_nettype none

module mts_checker
   import mts_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_out_count,
   input wire logic [7:0] rsp_out_first,
   input wire logic [7:0] rsp_out_second,
   input wire logic       rsp_text_end
);

   // a result never claims more than two bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_count != 2'd3)
      else $error("result byte count out of range");

   // the second byte lane reads as zero unless the result holds two bytes
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_count != 2'd2) |-> rsp_out_second == CHAR_NONE)
      else $error("second byte set without a two-byte result");

   // a two-byte result is only ever the example marker
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_count == 2'd2)
         |-> (rsp_out_first == CHAR_DASH && rsp_out_second == CHAR_SPACE))
      else $error("unexpected two-byte result");

   // no result appears without an accepted request right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_count)
         && $stable(rsp_out_first) && $stable(rsp_out_second)
         && $stable(rsp_text_end)))
      else $error("stalled result changed");

endmodule

bind markup_tag_stripper mts_checker u_mts_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_count  (rsp_out_count),
   .rsp_out_first  (rsp_out_first),
   .rsp_out_second (rsp_out_second),
   .rsp_text_end   (rsp_text_end)
);

`default_nettype wire

FILE: verif/markup_tag_stripper_tb.sv
// Self-checking testbench for the markup tag stripper: directed table, random texts, checks.
`timescale 1ns / 1ps

module markup_tag_stripper_tb;
   import mts_pkg::*;

   localparam int TAG_COUNT       = NUM_PATTERNS;
   localparam int TAG_LV6         = PAT_LV6;
   localparam int TAG_EXA         = PAT_EXA;
   localparam int DIRECTED_COUNT  = 26;
   localparam int RANDOM_ITEMS    = 1150;
   localparam int RSP_HOLD_CYCLES = 40;
   localparam int IDLE_PCT        = 30;

   typedef enum logic [1:0] {SCAN_TEXT, SCAN_MATCH, SCAN_SKIP, SCAN_DROP} scan_mode_type;

   // One row of the directed table; the typed result applies only when typed is set
   typedef struct packed {
      char_type   text_byte;
      logic       last;
      logic       typed;
      logic [1:0] count;
      char_type   first;
      char_type   second;
   } directed_row_type;

   typedef struct packed {
      char_type   text_byte;
      logic       last;
      logic       typed;
      result_type want;
   } request_item_type;

   // Byte patterns of the recognised tags, in the order of the block's pattern table
   string tag_text [TAG_COUNT] = '{
      "</LV0>", "</LV2>", "</LV3>", "</LV4>", "</LV5>", "<LV2>", "<LV3>", "<LV6", "<EXA>"
   };

   // Extremes of the byte, every emitting tag kind, early '>', tags cut or
   // completed by the final byte
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{8'h00, 1'b0, 1'b1, 2'd1, 8'h00,     CHAR_NONE},
      '{8'hFF, 1'b0, 1'b1, 2'd1, 8'hFF,     CHAR_NONE},
      '{"<",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"E",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"X",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"A",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{">",   1'b0, 1'b1, 2'd2, CHAR_DASH, CHAR_SPACE},
      '{"<",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"L",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"V",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"6",   1'b0, 1'b1, 2'd1, CHAR_NL,   CHAR_NONE},
      '{"Q",   1'b0, 1'b1, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"<",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{">",   1'b0, 1'b1, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"<",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"/",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"L",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"V",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"0",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{">",   1'b1, 1'b1, 2'd1, CHAR_NL,   CHAR_NONE},
      '{"<",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"L",   1'b1, 1'b1, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"<",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"L",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"V",   1'b0, 1'b0, 2'd0, CHAR_NONE, CHAR_NONE},
      '{"6",   1'b1, 1'b1, 2'd1, CHAR_NL,   CHAR_NONE}
   };

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   char_type   req_text_byte  = CHAR_NONE;
   logic       req_last       = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [1:0] rsp_out_count;
   char_type   rsp_out_first;
   char_type   rsp_out_second;
   logic       rsp_text_end;

   // Side information that travels with the request on the payload
   logic       req_typed      = 1'b0;
   result_type req_want       = '0;

   request_item_type request_q [$];
   result_type       cleaned_q [$];
   int               failures = 0;

   // Scanner state of the predictor
   scan_mode_type scan_state = SCAN_TEXT;
   pos_type       scan_pos   = '0;
   cand_type      scan_cand  = '0;

   markup_tag_stripper dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_byte  (req_text_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_count  (rsp_out_count),
      .rsp_out_first  (rsp_out_first),
      .rsp_out_second (rsp_out_second),
      .rsp_text_end   (rsp_text_end)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Advance the predictor by one text byte and return the cleaned output it gives
   function automatic result_type strip_step(input char_type b, input logic lst);
      result_type r;
      cand_type   keep;
      int         hit;
      r          = '0;
      r.text_end = lst;
      keep       = '0;
      hit        = -1;
      unique case (scan_state)
         SCAN_TEXT: begin
            if (b == CHAR_LT) begin
               scan_state = SCAN_MATCH;
               scan_pos   = 3'd1;
               scan_cand  = '1;
            end else begin
               r.out_count = 2'd1;
               r.out_first = b;
            end
         end
         SCAN_MATCH: begin
            // Narrow the candidates; a pattern whose last byte matches here wins
            for (int i = 0; i < TAG_COUNT; i++) begin
               if (scan_cand[i] && scan_pos < tag_text[i].len() &&
                   char_type'(tag_text[i][scan_pos]) == b) begin
                  keep[i] = 1'b1;
                  if (scan_pos + 1 == tag_text[i].len())
                     hit = i;
               end
            end
            scan_cand = keep;
            if (hit >= 0) begin
               if (hit == TAG_EXA) begin
                  r.out_count  = 2'd2;
                  r.out_first  = CHAR_DASH;
                  r.out_second = CHAR_SPACE;
               end else begin
                  r.out_count = 2'd1;
                  r.out_first = CHAR_NL;
               end
               scan_state = (hit == TAG_LV6) ? SCAN_DROP : SCAN_TEXT;
               scan_pos   = '0;
               scan_cand  = '0;
            end else if (keep == '0) begin
               scan_state = (b == CHAR_GT) ? SCAN_TEXT : SCAN_SKIP;
               scan_pos   = '0;
            end else begin
               scan_pos = scan_pos + 3'd1;
            end
         end
         SCAN_SKIP: begin
            if (b == CHAR_GT)
               scan_state = SCAN_TEXT;
         end
         default: begin
            scan_state = SCAN_TEXT;
         end
      endcase
      // The final byte of a text returns the scanner to its reset state
      if (lst) begin
         scan_state = SCAN_TEXT;
         scan_pos   = '0;
         scan_cand  = '0;
      end
      return r;
   endfunction

   task automatic queue_byte(input char_type b);
      request_item_type item;
      item           = '0;
      item.text_byte = b;
      request_q.push_back(item);
   endtask

   // Build one random text: mostly well-formed tags and plain text, with some
   // unknown tags, broken prefixes and raw noise; the final byte may cut a tag
   task automatic queue_random_text();
      int       kind;
      int       tag;
      int       cut;
      char_type b;
      repeat ($urandom_range(1, 10)) begin
         kind = $urandom_range(0, 9);
         tag  = $urandom_range(0, TAG_COUNT - 1);
         unique case (kind)
            0, 1, 2: begin
               repeat ($urandom_range(1, 3)) begin
                  do b = char_type'($urandom_range(0, 255)); while (b == CHAR_LT);
                  queue_byte(b);
               end
            end
            3, 4, 5, 6: begin
               for (int j = 0; j < tag_text[tag].len(); j++)
                  queue_byte(tag_text[tag][j]);
               if (tag == TAG_LV6)
                  queue_byte(char_type'($urandom_range(0, 255)));
            end
            7: begin
               queue_byte(CHAR_LT);
               repeat ($urandom_range(0, 4)) begin
                  do b = char_type'($urandom_range(0, 255)); while (b == CHAR_GT);
                  queue_byte(b);
               end
               queue_byte(CHAR_GT);
            end
            8: begin
               cut = $urandom_range(1, tag_text[tag].len() - 1);
               for (int j = 0; j < cut; j++)
                  queue_byte(tag_text[tag][j]);
               queue_byte(char_type'($urandom_range(0, 255)));
            end
            default: begin
               queue_byte(char_type'($urandom_range(0, 255)));
            end
         endcase
      end
      request_q[request_q.size() - 1].last = 1'b1;
   endtask

   task automatic check_field(input string field, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
         failures++;
      end
   endtask

   // Score results first, then record the request taken at the same edge:
   // results are registered, so a result can never belong to that request
   always @(posedge clock) begin : scoreboard
      result_type want_r;
      result_type seen_r;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_r = '{rsp_out_count, rsp_out_first, rsp_out_second, rsp_text_end};
            if (cleaned_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h", $time, seen_r);
               failures++;
            end else begin
               want_r = cleaned_q.pop_front();
               check_field("out_count", want_r.out_count, seen_r.out_count);
               check_field("out_first", want_r.out_first, seen_r.out_first);
               check_field("out_second", want_r.out_second, seen_r.out_second);
               check_field("text_end", want_r.text_end, seen_r.text_end);
            end
         end
         if (req_valid && req_ready) begin
            want_r = strip_step(req_text_byte, req_last);
            cleaned_q.push_back(req_typed ? req_want : want_r);
         end
      end
   end

   // Receiver: random back-pressure, one long hold-off to fill the block and
   // stall its input, and a stretch of full readiness
   initial begin : receiver
      int rx_seen;
      int hold_left;
      bit hold_done;
      rx_seen   = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            rx_seen++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rx_seen >= 600) begin
            hold_done = 1'b1;
            hold_left = RSP_HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (rx_seen >= 700 && rx_seen < 950) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin : sender
      request_item_type item;
      int               sent;
      bit               idle;
      // Directed table first; the typed rows carry their own result
      for (int k = 0; k < DIRECTED_COUNT; k++) begin
         item.text_byte = DIRECTED_ROWS[k].text_byte;
         item.last      = DIRECTED_ROWS[k].last;
         item.typed     = DIRECTED_ROWS[k].typed;
         item.want      = '{DIRECTED_ROWS[k].count, DIRECTED_ROWS[k].first,
                            DIRECTED_ROWS[k].second, DIRECTED_ROWS[k].last};
         request_q.push_back(item);
      end
      while (request_q.size() < DIRECTED_COUNT + RANDOM_ITEMS)
         queue_random_text();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      sent = 0;
      while (sent < request_q.size()) begin
         @(posedge clock);
         if (req_valid && req_ready)
            sent++;
         // Hold the payload while a request waits; otherwise offer the next or idle
         if (!(req_valid && !req_ready)) begin
            idle = !(sent >= 550 && sent < 800) && ($urandom_range(0, 99) < IDLE_PCT);
            if (sent < request_q.size() && !idle) begin
               req_valid     <= 1'b1;
               req_text_byte <= request_q[sent].text_byte;
               req_last      <= request_q[sent].last;
               req_typed     <= request_q[sent].typed;
               req_want      <= request_q[sent].want;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end

      // Drain the outstanding results, then allow the block's latency to pass
      while (cleaned_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (cleaned_q.size() != 0) begin
         $display("%0t: %0d results still expected, actual none", $time, cleaned_q.size());
         failures++;
      end
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
